// ===== hw/rtl/afc_pkg.sv =====
`timescale 1ns / 1ps

package afc_pkg;

   // plane storage and field widths
   localparam int PLANE_COUNT = 6;
   localparam int IDX_W       = 3;
   localparam int NRM_W       = 18;
   localparam int CRD_W       = 32;
   localparam int OFF_W       = 32;
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = NRM_W + CRD_W;    // Q18.32 product
   localparam int OFFS_W      = OFF_W + FRAC_W;   // offset aligned to Q16.32
   localparam int ACC_W       = PROD_W + 2;       // three products plus offset

   // item codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TEST  = 1'b1;

   // one item as it travels down the chain
   typedef struct packed {
      logic                     func;
      logic [IDX_W-1:0]         plane_index;
      logic signed [NRM_W-1:0]  normal_x;
      logic signed [NRM_W-1:0]  normal_y;
      logic signed [NRM_W-1:0]  normal_z;
      logic signed [OFF_W-1:0]  plane_offset;
      logic signed [CRD_W-1:0]  min_x;
      logic signed [CRD_W-1:0]  min_y;
      logic signed [CRD_W-1:0]  min_z;
      logic signed [CRD_W-1:0]  max_x;
      logic signed [CRD_W-1:0]  max_y;
      logic signed [CRD_W-1:0]  max_z;
   } afc_item_type;

   // item plus running verdict between cells
   typedef struct packed {
      afc_item_type item;
      logic         visible;
   } afc_stage_type;

endpackage

// ===== hw/rtl/aabb_frustum_cull.sv =====
`timescale 1ns / 1ps

// Each plane cell has a product stage and a sum stage; a box test passes them in turn,
// then the output register. One item per cycle unless rsp_ready holds back a response.
// Plane writes give no response and take effect for every box test after them.
// Reset (synchronous, active high) clears all planes to zero and empties the pipeline.
module aabb_frustum_cull (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [afc_pkg::IDX_W-1:0]           req_plane_index,
   input  logic signed [afc_pkg::NRM_W-1:0]    req_normal_x,
   input  logic signed [afc_pkg::NRM_W-1:0]    req_normal_y,
   input  logic signed [afc_pkg::NRM_W-1:0]    req_normal_z,
   input  logic signed [afc_pkg::OFF_W-1:0]    req_plane_offset,
   input  logic signed [afc_pkg::CRD_W-1:0]    req_min_x,
   input  logic signed [afc_pkg::CRD_W-1:0]    req_min_y,
   input  logic signed [afc_pkg::CRD_W-1:0]    req_min_z,
   input  logic signed [afc_pkg::CRD_W-1:0]    req_max_x,
   input  logic signed [afc_pkg::CRD_W-1:0]    req_max_y,
   input  logic signed [afc_pkg::CRD_W-1:0]    req_max_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_box_inside
);

   logic                    chain_valid [afc_pkg::PLANE_COUNT+1];
   logic                    chain_ready [afc_pkg::PLANE_COUNT+1];
   afc_pkg::afc_stage_type  chain_data  [afc_pkg::PLANE_COUNT+1];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_inside_ff;
   logic                    tail_is_test, out_free;

   // chain head
   always_comb begin
      chain_data[0].item.func         = req_func;
      chain_data[0].item.plane_index  = req_plane_index;
      chain_data[0].item.normal_x     = req_normal_x;
      chain_data[0].item.normal_y     = req_normal_y;
      chain_data[0].item.normal_z     = req_normal_z;
      chain_data[0].item.plane_offset = req_plane_offset;
      chain_data[0].item.min_x        = req_min_x;
      chain_data[0].item.min_y        = req_min_y;
      chain_data[0].item.min_z        = req_min_z;
      chain_data[0].item.max_x        = req_max_x;
      chain_data[0].item.max_y        = req_max_y;
      chain_data[0].item.max_z        = req_max_z;
      chain_data[0].visible           = 1'b1;
   end
   assign chain_valid[0] = req_valid;
   assign req_ready      = chain_ready[0];

   // one cell per plane
   for (genvar k = 0; k < afc_pkg::PLANE_COUNT; k++) begin : g_cell
      afc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (afc_pkg::IDX_W'(k)),
         .up_valid (chain_valid[k]),
         .up_data  (chain_data[k]),
         .up_ready (chain_ready[k]),
         .dn_valid (chain_valid[k+1]),
         .dn_data  (chain_data[k+1]),
         .dn_ready (chain_ready[k+1])
      );
   end

   // chain tail: writes are dropped, tests go to the output register
   assign tail_is_test = chain_data[afc_pkg::PLANE_COUNT].item.func == afc_pkg::FUNC_TEST;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign chain_ready[afc_pkg::PLANE_COUNT] = !tail_is_test || out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = chain_valid[afc_pkg::PLANE_COUNT] && tail_is_test;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && chain_valid[afc_pkg::PLANE_COUNT] && tail_is_test) begin
         rsp_inside_ff <= chain_data[afc_pkg::PLANE_COUNT].visible;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_box_inside = rsp_inside_ff;

endmodule

// ===== hw/rtl/afc_cell.sv =====
`timescale 1ns / 1ps

// One plane of the frustum. Products in the first stage, sum and sign test
// in the second. Plane writes travel down the chain and load the cell whose
// index they name, so they stay ordered against box tests.
module afc_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [afc_pkg::IDX_W-1:0]     cell_idx,
   input  logic                          up_valid,
   input  afc_pkg::afc_stage_type        up_data,
   output logic                          up_ready,
   output logic                          dn_valid,
   output afc_pkg::afc_stage_type        dn_data,
   input  logic                          dn_ready
);

   // plane held by this cell
   logic signed [afc_pkg::NRM_W-1:0]  nx_ff, ny_ff, nz_ff;
   logic signed [afc_pkg::OFF_W-1:0]  off_ff;

   // product stage
   logic                              a_valid_ff;
   afc_pkg::afc_stage_type            a_data_ff;
   logic signed [afc_pkg::PROD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [afc_pkg::OFFS_W-1:0] po_ff;

   // sum stage
   logic                              b_valid_ff;
   afc_pkg::afc_stage_type            b_data_ff;

   logic                              a_ready, b_ready, load_a, plane_wr;
   logic signed [afc_pkg::CRD_W-1:0]  cx, cy, cz;
   logic signed [afc_pkg::PROD_W-1:0] px_in, py_in, pz_in;
   logic signed [afc_pkg::OFFS_W-1:0] po_in;
   logic signed [afc_pkg::ACC_W-1:0]  acc;
   logic                              outside;

   // elastic handshake: a stage takes data when empty or draining
   assign b_ready  = !b_valid_ff || dn_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign up_ready = a_ready;
   assign load_a   = up_valid && a_ready;
   assign plane_wr = load_a && (up_data.item.func == afc_pkg::FUNC_WRITE) &&
                     (up_data.item.plane_index == cell_idx);

   // nearest corner: min where the normal component is strictly positive
   always_comb begin
      cx = (!nx_ff[afc_pkg::NRM_W-1] && (nx_ff != '0)) ? up_data.item.min_x
                                                      : up_data.item.max_x;
      cy = (!ny_ff[afc_pkg::NRM_W-1] && (ny_ff != '0)) ? up_data.item.min_y
                                                      : up_data.item.max_y;
      cz = (!nz_ff[afc_pkg::NRM_W-1] && (nz_ff != '0)) ? up_data.item.min_z
                                                      : up_data.item.max_z;
      px_in = afc_pkg::PROD_W'(nx_ff) * afc_pkg::PROD_W'(cx);
      py_in = afc_pkg::PROD_W'(ny_ff) * afc_pkg::PROD_W'(cy);
      pz_in = afc_pkg::PROD_W'(nz_ff) * afc_pkg::PROD_W'(cz);
      po_in = signed'({off_ff, afc_pkg::FRAC_W'(0)});
   end

   // dot product plus offset, culled when strictly positive
   always_comb begin
      acc = afc_pkg::ACC_W'(px_ff) + afc_pkg::ACC_W'(py_ff) +
            afc_pkg::ACC_W'(pz_ff) + afc_pkg::ACC_W'(po_ff);
      outside = !acc[afc_pkg::ACC_W-1] && (acc != '0);
   end

   // plane registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff  <= '0;
         ny_ff  <= '0;
         nz_ff  <= '0;
         off_ff <= '0;
      end else if (plane_wr) begin
         nx_ff  <= up_data.item.normal_x;
         ny_ff  <= up_data.item.normal_y;
         nz_ff  <= up_data.item.normal_z;
         off_ff <= up_data.item.plane_offset;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= up_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load_a) begin
         a_data_ff <= up_data;
         px_ff     <= px_in;
         py_ff     <= py_in;
         pz_ff     <= pz_in;
         po_ff     <= po_in;
      end
      if (a_valid_ff && b_ready) begin
         b_data_ff.item    <= a_data_ff.item;
         b_data_ff.visible <= a_data_ff.visible && !outside;
      end
   end

   assign dn_valid = b_valid_ff;
   assign dn_data  = b_data_ff;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import afc_pkg::*;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_ITEMS = 430;
   localparam int CALM_ITEMS   = 60;
   localparam int LONG_HOLD    = 200;
   localparam int HOLD_AFTER   = 40;
   localparam int DRAIN_CYCLES = 2 * PLANE_COUNT + 8;
   localparam int MAX_REPORTS  = 40;

   // plane slots
   localparam int PLANE_LEFT   = 0;
   localparam int PLANE_RIGHT  = 1;
   localparam int PLANE_TOP    = 2;
   localparam int PLANE_BOTTOM = 3;
   localparam int PLANE_NEAR   = 4;
   localparam int PLANE_FAR    = 5;
   localparam int PLANE_BAD_LO = PLANE_COUNT;
   localparam int PLANE_BAD_HI = PLANE_COUNT + 1;

   // fixed point landmarks
   localparam int                      FIX_ONE = 1 << FRAC_W;
   localparam logic signed [NRM_W-1:0] NRM_ONE = 18'sh10000;
   localparam logic signed [NRM_W-1:0] NRM_MAX = 18'sh1ffff;
   localparam logic signed [NRM_W-1:0] NRM_MIN = 18'sh20000;
   localparam logic signed [CRD_W-1:0] CRD_MAX = 32'sh7fff_ffff;
   localparam logic signed [CRD_W-1:0] CRD_MIN = 32'sh8000_0000;

   typedef struct {
      afc_item_type item;
      bit           has_fixed;
      bit           fixed_inside;
   } stim_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_func = FUNC_WRITE;
   logic [IDX_W-1:0]        req_plane_index = '0;
   logic signed [NRM_W-1:0] req_normal_x = '0;
   logic signed [NRM_W-1:0] req_normal_y = '0;
   logic signed [NRM_W-1:0] req_normal_z = '0;
   logic signed [OFF_W-1:0] req_plane_offset = '0;
   logic signed [CRD_W-1:0] req_min_x = '0;
   logic signed [CRD_W-1:0] req_min_y = '0;
   logic signed [CRD_W-1:0] req_min_z = '0;
   logic signed [CRD_W-1:0] req_max_x = '0;
   logic signed [CRD_W-1:0] req_max_y = '0;
   logic signed [CRD_W-1:0] req_max_z = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_box_inside;

   // travels with the payload: directed rows may carry a hand-typed answer
   logic                    row_has_fixed = 1'b0;
   logic                    row_fixed_inside = 1'b0;

   // predictor copy of the plane store
   logic signed [NRM_W-1:0] frustum_nx  [PLANE_COUNT];
   logic signed [NRM_W-1:0] frustum_ny  [PLANE_COUNT];
   logic signed [NRM_W-1:0] frustum_nz  [PLANE_COUNT];
   logic signed [OFF_W-1:0] frustum_off [PLANE_COUNT];

   logic         expected_inside [$];
   stim_row_type directed_rows [$];
   int           error_count = 0;
   int           results_seen = 0;
   bit           calm = 1'b0;
   bit           long_hold_done = 1'b0;

   aabb_frustum_cull u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_plane_index  (req_plane_index),
      .req_normal_x     (req_normal_x),
      .req_normal_y     (req_normal_y),
      .req_normal_z     (req_normal_z),
      .req_plane_offset (req_plane_offset),
      .req_min_x        (req_min_x),
      .req_min_y        (req_min_y),
      .req_min_z        (req_min_z),
      .req_max_x        (req_max_x),
      .req_max_y        (req_max_y),
      .req_max_z        (req_max_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_box_inside   (rsp_box_inside)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      foreach (frustum_nx[p]) begin
         frustum_nx[p]  = '0;
         frustum_ny[p]  = '0;
         frustum_nz[p]  = '0;
         frustum_off[p] = '0;
      end
   end

   // ---------------------------------------------------------------- predictor

   // product of one normal component with the corner coordinate nearest the inside
   function automatic longint near_product(input logic signed [NRM_W-1:0] n,
                                           input logic signed [CRD_W-1:0] lo, hi);
      return longint'(n) * ((n > 0) ? longint'(lo) : longint'(hi));
   endfunction

   function automatic logic predict_box_inside(input logic signed [CRD_W-1:0] lo_x, lo_y,
                                               lo_z, hi_x, hi_y, hi_z);
      longint margin;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         margin = near_product(frustum_nx[p], lo_x, hi_x)
                + near_product(frustum_ny[p], lo_y, hi_y)
                + near_product(frustum_nz[p], lo_z, hi_z)
                + (longint'(frustum_off[p]) <<< FRAC_W);
         if (margin > 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%0t ns: %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin : track_transfers
      logic want;
      if (!reset) begin
         // request side: update plane copy or queue the verdict
         if (req_valid && req_ready === 1'b1) begin
            if (req_func == FUNC_WRITE) begin
               if (req_plane_index < PLANE_COUNT) begin
                  frustum_nx[req_plane_index]  = req_normal_x;
                  frustum_ny[req_plane_index]  = req_normal_y;
                  frustum_nz[req_plane_index]  = req_normal_z;
                  frustum_off[req_plane_index] = req_plane_offset;
               end
            end else begin
               want = predict_box_inside(req_min_x, req_min_y, req_min_z,
                                         req_max_x, req_max_y, req_max_z);
               expected_inside.push_back(row_has_fixed ? row_fixed_inside : want);
            end
         end
         // response side
         if (rsp_valid === 1'b1 && rsp_ready) begin
            results_seen++;
            if (expected_inside.size() == 0) begin
               report_mismatch("response transfer with no box test pending");
            end else begin
               want = expected_inside.pop_front();
               if (rsp_box_inside !== want)
                  report_mismatch($sformatf("box_inside got %b, expected %b",
                                            rsp_box_inside, want));
            end
         end
      end
   end

   // ---------------------------------------------------------------- row builders
   function automatic stim_row_type plane_row(input int idx,
                                              input logic signed [NRM_W-1:0] nx, ny, nz,
                                              input logic signed [OFF_W-1:0] off);
      stim_row_type r;
      r.item              = '0;
      r.item.func         = FUNC_WRITE;
      r.item.plane_index  = idx[IDX_W-1:0];
      r.item.normal_x     = nx;
      r.item.normal_y     = ny;
      r.item.normal_z     = nz;
      r.item.plane_offset = off;
      r.has_fixed         = 1'b0;
      r.fixed_inside      = 1'b0;
      return r;
   endfunction

   function automatic stim_row_type box_row(input logic signed [CRD_W-1:0] lo_x, lo_y, lo_z,
                                            hi_x, hi_y, hi_z,
                                            input bit has_fixed, input bit fixed_inside);
      stim_row_type r;
      r.item         = '0;
      r.item.func    = FUNC_TEST;
      r.item.min_x   = lo_x;
      r.item.min_y   = lo_y;
      r.item.min_z   = lo_z;
      r.item.max_x   = hi_x;
      r.item.max_y   = hi_y;
      r.item.max_z   = hi_z;
      r.has_fixed    = has_fixed;
      r.fixed_inside = fixed_inside;
      return r;
   endfunction

   // every field random, used or not
   function automatic stim_row_type noise_row(input logic func);
      stim_row_type r;
      r.item.func         = func;
      r.item.plane_index  = IDX_W'($urandom);
      r.item.normal_x     = NRM_W'($urandom);
      r.item.normal_y     = NRM_W'($urandom);
      r.item.normal_z     = NRM_W'($urandom);
      r.item.plane_offset = $urandom;
      r.item.min_x        = $urandom;
      r.item.min_y        = $urandom;
      r.item.min_z        = $urandom;
      r.item.max_x        = $urandom;
      r.item.max_y        = $urandom;
      r.item.max_z        = $urandom;
      r.has_fixed         = 1'b0;
      r.fixed_inside      = 1'b0;
      return r;
   endfunction

   // unit-scale normal component, -1.0 .. +1.0
   function automatic logic signed [NRM_W-1:0] random_unit_component();
      int v;
      v = int'($urandom_range(0, 2 * FIX_ONE)) - FIX_ONE;
      return v[NRM_W-1:0];
   endfunction

   // ---------------------------------------------------------------- driver
   task automatic send_row(input stim_row_type row);
      req_valid        <= 1'b1;
      req_func         <= row.item.func;
      req_plane_index  <= row.item.plane_index;
      req_normal_x     <= row.item.normal_x;
      req_normal_y     <= row.item.normal_y;
      req_normal_z     <= row.item.normal_z;
      req_plane_offset <= row.item.plane_offset;
      req_min_x        <= row.item.min_x;
      req_min_y        <= row.item.min_y;
      req_min_z        <= row.item.min_z;
      req_max_x        <= row.item.max_x;
      req_max_y        <= row.item.max_y;
      req_max_z        <= row.item.max_z;
      row_has_fixed    <= row.has_fixed;
      row_fixed_inside <= row.fixed_inside;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
   endtask

   task automatic maybe_idle(input int gap_pct);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   initial begin
      stim_row_type row;
      int           accepted_items;
      int           gap_pct;
      int           pick;
      int           c;
      int           h;
      int           lo [3];
      int           hi [3];

      // directed: fresh store, extremes, ignored writes, corner selection
      directed_rows.push_back(box_row(0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
      directed_rows.push_back(box_row(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX,
                                      1'b1, 1'b1));
      directed_rows.push_back(box_row(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN, CRD_MIN,
                                      1'b1, 1'b1));
      directed_rows.push_back(plane_row(PLANE_BAD_LO, NRM_ONE, NRM_ONE, NRM_ONE, CRD_MAX));
      directed_rows.push_back(plane_row(PLANE_BAD_HI, NRM_MIN, NRM_MIN, NRM_MIN, 1));
      directed_rows.push_back(box_row(0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
      // offset-only plane: one LSB positive culls everything, zero culls nothing
      directed_rows.push_back(plane_row(PLANE_LEFT, '0, '0, '0, 1));
      directed_rows.push_back(box_row(0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
      directed_rows.push_back(plane_row(PLANE_LEFT, '0, '0, '0, 0));
      directed_rows.push_back(box_row(0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
      // x <= 4 and x >= -4; zero y/z components pick the max corner
      directed_rows.push_back(plane_row(PLANE_LEFT, NRM_ONE, '0, '0, -4 * FIX_ONE));
      directed_rows.push_back(box_row(5 * FIX_ONE, 0, 0, 6 * FIX_ONE, 0, 0, 1'b0, 1'b0));
      directed_rows.push_back(box_row(3 * FIX_ONE, 0, 0, 9 * FIX_ONE, 0, 0, 1'b0, 1'b0));
      directed_rows.push_back(plane_row(PLANE_RIGHT, -NRM_ONE, '0, '0, -4 * FIX_ONE));
      directed_rows.push_back(box_row(5 * FIX_ONE, -FIX_ONE, 0, -5 * FIX_ONE, FIX_ONE, 0,
                                      1'b0, 1'b0));
      // extreme normals and offsets against extreme boxes
      directed_rows.push_back(plane_row(PLANE_TOP, NRM_MAX, NRM_MIN, NRM_MAX, CRD_MIN));
      directed_rows.push_back(plane_row(PLANE_BOTTOM, NRM_MIN, NRM_MAX, NRM_MIN, CRD_MAX));
      directed_rows.push_back(box_row(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX,
                                      1'b0, 1'b0));
      directed_rows.push_back(box_row(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN, CRD_MIN,
                                      1'b0, 1'b0));
      directed_rows.push_back(plane_row(PLANE_NEAR, '0, '0, NRM_ONE, CRD_MIN));
      directed_rows.push_back(plane_row(PLANE_FAR, '0, '0, -NRM_ONE, -8 * FIX_ONE));
      directed_rows.push_back(box_row(-FIX_ONE, -FIX_ONE, -FIX_ONE, FIX_ONE, FIX_ONE, FIX_ONE,
                                      1'b0, 1'b0));
      directed_rows.push_back(box_row(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX,
                                      1'b0, 1'b0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_row(directed_rows[i]);
         maybe_idle(25);
      end

      // random part: mostly a plausible frustum with boxes around it, some noise
      accepted_items = 0;
      gap_pct        = 25;
      while (accepted_items < RANDOM_ITEMS) begin
         if (accepted_items % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       gap_pct = 0;
               1:       gap_pct = 15;
               default: gap_pct = 40;
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            row = noise_row(FUNC_WRITE);
            row.item.plane_index  = IDX_W'($urandom_range(0, PLANE_COUNT - 1));
            row.item.normal_x     = random_unit_component();
            row.item.normal_y     = random_unit_component();
            row.item.normal_z     = random_unit_component();
            if ($urandom_range(0, 7) == 0)
               row.item.plane_offset = $urandom_range(0, 2 * FIX_ONE);
            else
               row.item.plane_offset = -int'($urandom_range(FIX_ONE, 12 * FIX_ONE));
         end else if (pick < 18) begin
            row = noise_row(FUNC_WRITE);
         end else if (pick < 23) begin
            row = noise_row(FUNC_TEST);
         end else begin
            row = noise_row(FUNC_TEST);
            for (int a = 0; a < 3; a++) begin
               c = int'($urandom_range(0, 20 * FIX_ONE)) - 10 * FIX_ONE;
               h = int'($urandom_range(0, 3 * FIX_ONE));
               lo[a] = c - h;
               hi[a] = c + h;
               // occasionally hand the corners over swapped
               if ($urandom_range(0, 9) == 0) begin
                  lo[a] = c + h;
                  hi[a] = c - h;
               end
            end
            row.item.min_x = lo[0];
            row.item.min_y = lo[1];
            row.item.min_z = lo[2];
            row.item.max_x = hi[0];
            row.item.max_y = hi[1];
            row.item.max_z = hi[2];
         end
         send_row(row);
         // writes to a missing plane change nothing and do not count
         if (!(row.item.func == FUNC_WRITE && row.item.plane_index >= PLANE_COUNT))
            accepted_items++;
         if (RANDOM_ITEMS - accepted_items < CALM_ITEMS) calm = 1'b1;
         maybe_idle(gap_pct);
      end
      req_valid <= 1'b0;

      // drain, then give a few extra cycles for stray responses
      while (expected_inside.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver
   initial begin
      forever begin
         if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            // hold off long enough for the pipeline to back up into the input
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
            if (!calm) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 16)) @(posedge clock);
            end
         end
      end
   end

   // watchdog
   initial begin
      #1_600_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== aabb_frustum_cull.f =====
hw/rtl/afc_pkg.sv
hw/rtl/afc_cell.sv
hw/rtl/aabb_frustum_cull.sv
test/testbench.sv
